// ----- rtl/core/frs_pkg.sv -----
// Shared types and constants for the Fenwick range sum store.
package frs_pkg;

  // Fixed widths of the item fields and of the size register.
  localparam int IDX_W = 11;
  localparam int VAL_W = 32;

  // Size register value after reset.
  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // Sources for loading the tree walk index.
  localparam logic [1:0] KSEL_P1    = 2'd0;  // last index for a query, first for a set
  localparam logic [1:0] KSEL_P0    = 2'd1;  // first index minus one
  localparam logic [1:0] KSEL_FIRST = 2'd2;  // first index, start of an update walk

  // One input beat.
  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [VAL_W-1:0] value;
  } frs_in_t;

  // One result beat.
  typedef struct packed {
    logic signed [VAL_W-1:0] range_sum;
    logic                    status;
  } frs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_item;
    logic       sweep_init;
    logic       sweep_wr;
    logic       k_load;
    logic [1:0] k_sel;
    logic       k_down;
    logic       acc_clr;
    logic       acc_add;
    logic       rd_en;
    logic       save_a;
    logic       diff_load;
    logic       delta_load;
    logic       upd_wr;
    logic       res_load;
  } frs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic       k_zero;
    logic       k_over;
    logic       sweep_last;
    logic       out_free;
  } frs_sts_t;

endpackage

// ----- rtl/core/frs_dpath.sv -----
// Datapath of the Fenwick range sum store: node memory, walk index, sums and result register.
module frs_dpath import frs_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int SUM_WIDTH    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_wr_data,
  input  frs_in_t          in_data,
  input  logic             out_stall,
  output logic             out_valid,
  output frs_out_t         out_data,
  input  frs_cmd_t         cmd,
  output frs_sts_t         sts
);

  // Node address width and walk index width (the update walk may pass twice the size).
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int KW = (AW + 2 > IDX_W + 1) ? AW + 2 : IDX_W + 1;
  localparam logic [KW-1:0] MAX_K     = KW'(MAX_ELEMENTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

  logic [IDX_W-1:0]            size_r;
  frs_in_t                     item_r;
  logic [KW-1:0]               k_r;
  logic [KW-1:0]               k_nxt;
  logic [KW-1:0]               k_dec;
  logic [KW-1:0]               low_bit;
  logic [KW-1:0]               n_k;
  logic [KW-1:0]               first_k;
  logic [KW-1:0]               last_k;
  logic [AW-1:0]               node_addr;
  logic [AW-1:0]               sweep_r;
  logic [SUM_WIDTH-1:0]        mem [MAX_ELEMENTS];
  logic [SUM_WIDTH-1:0]        rdata_r;
  logic [SUM_WIDTH-1:0]        acc_r;
  logic [SUM_WIDTH-1:0]        a_r;
  logic signed [SUM_WIDTH-1:0] diff_r;
  logic signed [SUM_WIDTH-1:0] delta_r;
  logic signed [SUM_WIDTH-1:0] delta_nxt;
  logic signed [SUM_WIDTH-1:0] value_s;
  logic                        err;
  logic                        out_valid_r;
  frs_out_t                    out_data_r;

  // Size in effect, capped at the node count.
  assign n_k     = (KW'(size_r) > MAX_K) ? MAX_K : KW'(size_r);
  assign first_k = KW'(item_r.first_index);
  assign last_k  = KW'(item_r.last_index);

  // Range check of the captured item.
  always_comb begin
    case (item_r.mode)
      MODE_ADD,
      MODE_SET:   err = (first_k == '0) || (first_k > n_k);
      MODE_QUERY: err = (first_k == '0) || (last_k > n_k) || (first_k > last_k);
      default:    err = 1'b0;
    endcase
  end

  // Lowest set bit of the walk index and the node it addresses.
  assign low_bit   = k_r & (~k_r + KW'(1));
  assign k_dec     = k_r - KW'(1);
  assign node_addr = k_dec[AW-1:0];

  // Next walk index.
  always_comb begin
    k_nxt = k_r;
    if (cmd.k_load) begin
      case (cmd.k_sel)
        KSEL_P1:    k_nxt = (item_r.mode == MODE_QUERY) ? last_k : first_k;
        KSEL_P0:    k_nxt = first_k - KW'(1);
        KSEL_FIRST: k_nxt = first_k;
        default:    k_nxt = first_k;
      endcase
    end else if (cmd.k_down) begin
      k_nxt = k_r - low_bit;
    end else if (cmd.upd_wr) begin
      k_nxt = k_r + low_bit;
    end
  end

  // Value brought to node width; a set applies the difference to the old point value.
  assign value_s   = SUM_WIDTH'(item_r.value);
  assign delta_nxt = (item_r.mode == MODE_SET) ? value_s - diff_r : value_s;

  // Size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_init) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= sweep_r + AW'(1);
    end
  end

  // Node memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[sweep_r] <= '0;
    end else if (cmd.upd_wr) begin
      mem[node_addr] <= rdata_r + delta_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[node_addr];
    end
  end

  // Item capture, walk index and running sums.
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item_r <= in_data;
    end
    k_r <= k_nxt;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + rdata_r;
    end
    if (cmd.save_a) begin
      a_r <= acc_r;
    end
    if (cmd.diff_load) begin
      diff_r <= a_r - acc_r;
    end
    if (cmd.delta_load) begin
      delta_r <= delta_nxt;
    end
  end

  // Result register; a new beat loads only when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r.range_sum <= (item_r.mode == MODE_QUERY && !err) ? VAL_W'(diff_r) : '0;
      out_data_r.status    <= err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  assign sts.mode       = item_r.mode;
  assign sts.err        = err;
  assign sts.k_zero     = (k_r == '0);
  assign sts.k_over     = (k_r > n_k);
  assign sts.sweep_last = (sweep_r == LAST_ADDR);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ----- rtl/core/frs_ctrl.sv -----
// Controller state machine of the Fenwick range sum store.
module frs_ctrl import frs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  frs_sts_t sts,
  output frs_cmd_t cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_CLR    = 4'd3;
  localparam logic [3:0] S_PA_RD  = 4'd4;
  localparam logic [3:0] S_PA_ACC = 4'd5;
  localparam logic [3:0] S_PB_RD  = 4'd6;
  localparam logic [3:0] S_PB_ACC = 4'd7;
  localparam logic [3:0] S_DELTA  = 4'd8;
  localparam logic [3:0] S_UP_RD  = 4'd9;
  localparam logic [3:0] S_UP_WR  = 4'd10;
  localparam logic [3:0] S_RESULT = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mode == MODE_CLEAR) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_CLR;
        end else if (sts.err) begin
          state_nxt = S_RESULT;
        end else if (sts.mode == MODE_ADD) begin
          cmd.k_load     = 1'b1;
          cmd.k_sel      = KSEL_FIRST;
          cmd.delta_load = 1'b1;
          state_nxt      = S_UP_RD;
        end else begin
          cmd.k_load  = 1'b1;
          cmd.k_sel   = KSEL_P1;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_PA_RD;
        end
      end
      S_CLR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_RESULT;
        end
      end
      // First prefix walk, downward by the lowest set bit.
      S_PA_RD: begin
        if (sts.k_zero) begin
          cmd.save_a  = 1'b1;
          cmd.k_load  = 1'b1;
          cmd.k_sel   = KSEL_P0;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_PB_RD;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_PA_ACC;
        end
      end
      S_PA_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.k_down  = 1'b1;
        state_nxt   = S_PA_RD;
      end
      // Second prefix walk, up to the element before the range.
      S_PB_RD: begin
        if (sts.k_zero) begin
          cmd.diff_load = 1'b1;
          state_nxt     = (sts.mode == MODE_QUERY) ? S_RESULT : S_DELTA;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_PB_ACC;
        end
      end
      S_PB_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.k_down  = 1'b1;
        state_nxt   = S_PB_RD;
      end
      S_DELTA: begin
        cmd.delta_load = 1'b1;
        cmd.k_load     = 1'b1;
        cmd.k_sel      = KSEL_FIRST;
        state_nxt      = S_UP_RD;
      end
      // Update walk: read, add and write back each node up to the size.
      S_UP_RD: begin
        if (sts.k_zero || sts.k_over) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_UP_RD;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/fenwick_range_sum_store_core.sv -----
// Top level of the Fenwick range sum store: controller plus datapath.
//
//   Port group   Dir   Handshake            Beat
//   cfg_         in    cfg_wr_en            size in use, 11 bits
//   in_          in    in_valid / in_stall  mode, first_index, last_index, value
//   out_         out   out_valid / out_stall range_sum, status
//
// One item is worked at a time; each tree node access on the single node memory port first
// issues the read, then accumulates or writes back. A query walks popcount(last) +
// popcount(first - 1) nodes, an add its update path, a set both prefix paths and then its
// update path, a clear all MAX_ELEMENTS nodes; an error goes straight to the result. The
// clearing pass after reset stalls input until it has swept every node. Idle follows each
// result; a stalled beat holds only the next result back.
module fenwick_range_sum_store_core import frs_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int SUM_WIDTH    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  frs_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output frs_out_t         out_data
);

  frs_cmd_t cmd;
  frs_sts_t sts;

  // Sequencing.
  frs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  frs_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

`ifndef SYNTHESIS
  // The clearing pass after reset holds off input beats.
  a_reset_sweep_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // An accepted beat keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken before the first was worked");

  // An error result never carries a sum.
  a_err_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.range_sum == '0))
    else $error("error result with nonzero sum");
`endif

endmodule
